/* sv/ncexp_pkg.sv */
`timescale 1ns / 1ps
package ncexp_pkg;

    localparam int SLOTS       = 128;
    localparam int SLOT_W      = 7;
    localparam int NAME_BYTES  = 128;
    localparam int NAME_WORDS  = 16;
    localparam int WORD_W      = 4;
    localparam int CHUNK_CHARS = 8;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;
    localparam logic [1:0] REQ_FLUSH   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_REJECTED  = 2'd3;

    localparam logic [31:0] LOCAL_ADDRESS    = 32'h7F00_0001;
    localparam logic [23:0] TICKS_PER_SECOND = 24'd10000000;
    // "localhos" packed first character in the low byte, then the final 't'
    localparam logic [63:0] LOCAL_WORD0      = 64'h736F_686C_6163_6F6C;
    localparam logic [7:0]  LOCAL_LAST_CHAR  = 8'h74;
    localparam logic [7:0]  LOCAL_LEN        = 8'd9;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic [6:0]  name_len;
        logic [31:0] address;
        logic [31:0] lifetime;
        logic [63:0] insert_time;
    } meta_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        fold_char = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic [63:0] fold_word(input logic [63:0] w);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = fold_char(w[8*i +: 8]);
        end
        fold_word = r;
    endfunction

endpackage

/* sv/name_cache_with_expiry_top.sv */
`timescale 1ns / 1ps
// Name cache with expiry: maps names to IPv4 addresses with a time to live.
// Input channel (s_*): one transaction per name chunk of up to eight characters.
//   A chunk without s_last_chunk is absorbed and yields nothing.
//   The last chunk carries operation, address, lifetime and current time, and
//   yields exactly one result transaction on the m_* channel.
// Configuration: cfg_wr_en writes cfg_wr_data into the enable bit at once.
// A last chunk is worked on by a sequencer walking the 128 slots one at a
//   time over single-port slot memories. Flush clears all slots; insert
//   takes the first free slot and copies the name in 8-character words;
//   remove and resolve walk the slots, comparing length, then each word,
//   and resolve first checks for localhost and checks expiry on a match.
// s_ready is high only while the sequencer idles, so one request is worked
//   on at a time. The result sits in an output register; if the receiver
//   stalls, the sequencer holds in its final state until the register frees.
// Reset (aresetn low, synchronous): all slots invalid, count zero, block
//   disabled, any partially streamed name dropped.
module name_cache_with_expiry_top import ncexp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_name_chunk,
    input  logic [3:0]  s_chunk_bytes,
    input  logic        s_last_chunk,
    input  logic [31:0] s_entry_address,
    input  logic [31:0] s_ttl_seconds,
    input  logic [63:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_found_address,
    output logic [7:0]  m_entries_in_use
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_FIN      = 5'd1;
    localparam logic [4:0] ST_LOC0     = 5'd2;
    localparam logic [4:0] ST_LOC1     = 5'd3;
    localparam logic [4:0] ST_LOC2     = 5'd4;
    localparam logic [4:0] ST_INS_SCAN = 5'd5;
    localparam logic [4:0] ST_COPY_RD  = 5'd6;
    localparam logic [4:0] ST_COPY_WR  = 5'd7;
    localparam logic [4:0] ST_INS_META = 5'd8;
    localparam logic [4:0] ST_WALK     = 5'd9;
    localparam logic [4:0] ST_W_LEN    = 5'd10;
    localparam logic [4:0] ST_CMP      = 5'd11;
    localparam logic [4:0] ST_CMP_WAIT = 5'd12;
    localparam logic [4:0] ST_MATCH    = 5'd13;
    localparam logic [4:0] ST_EXP      = 5'd14;
    localparam logic [4:0] ST_NEXT     = 5'd15;
    localparam logic [4:0] ST_DONE     = 5'd16;

    // Sequencer and bookkeeping
    logic [4:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] word_cnt_reg, word_cnt_next;
    logic [SLOTS-1:0]  slot_valid_reg, slot_valid_next;
    logic [7:0]        count_reg, count_next;
    logic              enabled_reg;

    // Request name assembly
    logic [7:0]  rlen_reg, rlen_next;
    logic        zfound_reg, zfound_next;
    logic [7:0]  zpos_reg, zpos_next;
    logic [63:0] partial_reg, partial_next;

    // Latched request
    logic [1:0]  op_reg, op_next;
    logic [31:0] addr_in_reg, addr_in_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [63:0] now_reg, now_next;
    logic [7:0]  len_reg, len_next;
    logic        loc_ok_reg, loc_ok_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_addr_reg, res_addr_next;

    // Expiry check
    logic [55:0] prod_reg, prod_next;
    logic [63:0] diff_reg, diff_next;
    logic        ge_reg, ge_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [31:0] m_addr_reg, m_addr_next;
    logic [7:0]  m_count_reg, m_count_next;

    // Memories
    logic [63:0] req_mem [NAME_WORDS];
    logic [63:0] slot_name_mem [SLOTS*NAME_WORDS];
    meta_t       meta_mem [SLOTS];
    logic [63:0] req_rdata_reg;
    logic [63:0] name_rdata_reg;
    meta_t       meta_rdata_reg;

    logic              req_we;
    logic [WORD_W-1:0] req_waddr;
    logic [63:0]       req_wdata;
    logic              name_we;
    logic              meta_we;
    meta_t             meta_wdata;

    // Chunk intake datapath
    logic         accept;
    logic [3:0]   n_clip, n_eff;
    logic [7:0]   room, len_sum;
    logic [63:0]  masked;
    logic [127:0] merged;
    logic [4:0]   tot;
    logic         zf;
    logic [7:0]   zp;

    // Walk helpers
    logic [6:0]  keep;
    logic [4:0]  copy_words, cmp_words;
    logic [7:0]  rem;
    logic        cmp_eq;
    logic        expired;
    logic [63:0] name_a_fold, name_b_fold;

    assign s_ready          = (state_reg == ST_IDLE);
    assign accept           = s_valid && s_ready;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_address  = m_addr_reg;
    assign m_entries_in_use = m_count_reg;

    // Clip the chunk, drop characters past the name buffer, merge into the word stream
    always_comb begin
        n_clip = (s_chunk_bytes > 4'(CHUNK_CHARS)) ? 4'(CHUNK_CHARS) : s_chunk_bytes;
        room   = 8'(NAME_BYTES) - rlen_reg;
        n_eff  = ({4'd0, n_clip} > room) ? room[3:0] : n_clip;
        zf     = zfound_reg;
        zp     = zpos_reg;
        for (int i = 0; i < 8; i++) begin
            masked[8*i +: 8] = (4'(i) < n_eff) ? s_name_chunk[8*i +: 8] : 8'd0;
            if (!zf && (4'(i) < n_eff) && (s_name_chunk[8*i +: 8] == 8'd0)) begin
                zf = 1'b1;
                zp = rlen_reg + 8'(i);
            end
        end
        merged  = {64'd0, partial_reg} | ({64'd0, masked} << {rlen_reg[2:0], 3'b000});
        tot     = {2'b00, rlen_reg[2:0]} + {1'b0, n_eff};
        len_sum = rlen_reg + {4'd0, n_eff};
    end

    always_comb begin
        keep        = (len_reg > 8'(NAME_BYTES - 1)) ? 7'(NAME_BYTES - 1) : len_reg[6:0];
        copy_words  = 5'(({1'b0, keep} + 8'd7) >> 3);
        cmp_words   = 5'(({1'b0, len_reg} + 9'd7) >> 3);
        rem         = len_reg - {1'b0, word_cnt_reg, 3'b000};
        name_a_fold = fold_word(name_rdata_reg);
        name_b_fold = fold_word(req_rdata_reg);
        cmp_eq      = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if ((8'(i) < rem) && (name_a_fold[8*i +: 8] != name_b_fold[8*i +: 8])) begin
                cmp_eq = 1'b0;
            end
        end
        expired = ge_reg ? (diff_reg >= {8'd0, prod_reg})
                         : ((diff_reg >= 64'(TICKS_PER_SECOND)) || (prod_reg == 56'd0));
    end

    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        word_cnt_next   = word_cnt_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        rlen_next       = rlen_reg;
        zfound_next     = zfound_reg;
        zpos_next       = zpos_reg;
        partial_next    = partial_reg;
        op_next         = op_reg;
        addr_in_next    = addr_in_reg;
        ttl_next        = ttl_reg;
        now_next        = now_reg;
        len_next        = len_reg;
        loc_ok_next     = loc_ok_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        prod_next       = prod_reg;
        diff_next       = diff_reg;
        ge_next         = ge_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_count_next    = m_count_reg;
        req_we          = 1'b0;
        req_waddr       = rlen_reg[6:3];
        req_wdata       = merged[63:0];
        name_we         = 1'b0;
        meta_we         = 1'b0;
        meta_wdata      = '{name_len: keep, address: addr_in_reg,
                            lifetime: ttl_reg, insert_time: now_reg};

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rlen_next   = len_sum;
                    zfound_next = zf;
                    zpos_next   = zp;
                    if (tot >= 5'd8) begin
                        req_we       = 1'b1;
                        partial_next = merged[127:64];
                    end else begin
                        partial_next = merged[63:0];
                    end
                    if (s_last_chunk) begin
                        op_next         = s_req_type;
                        addr_in_next    = s_entry_address;
                        ttl_next        = s_ttl_seconds;
                        now_next        = s_now_time;
                        len_next        = zf ? zp : len_sum;
                        res_status_next = STAT_NOT_FOUND;
                        res_addr_next   = 32'd0;
                        state_next      = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Flush the trailing partial word, then dispatch
                req_waddr     = rlen_reg[6:3];
                req_wdata     = partial_reg;
                req_we        = (rlen_reg[2:0] != 3'd0);
                rlen_next     = 8'd0;
                zfound_next   = 1'b0;
                partial_next  = 64'd0;
                slot_next     = '0;
                word_cnt_next = '0;
                unique case (op_reg)
                    REQ_FLUSH: begin
                        slot_valid_next = '0;
                        count_next      = 8'd0;
                        res_status_next = STAT_OK;
                        state_next      = ST_DONE;
                    end
                    REQ_INSERT: begin
                        if (!enabled_reg) begin
                            res_status_next = STAT_REJECTED;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_INS_SCAN;
                        end
                    end
                    REQ_REMOVE:  state_next = ST_WALK;
                    REQ_RESOLVE: state_next = ST_LOC0;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_LOC0: begin
                word_cnt_next = 4'd1;
                state_next    = ST_LOC1;
            end
            ST_LOC1: begin
                loc_ok_next = (name_b_fold == LOCAL_WORD0);
                state_next  = ST_LOC2;
            end
            ST_LOC2: begin
                if (loc_ok_reg && (len_reg == LOCAL_LEN)
                        && (name_b_fold[7:0] == LOCAL_LAST_CHAR)) begin
                    res_status_next = STAT_OK;
                    res_addr_next   = LOCAL_ADDRESS;
                    state_next      = ST_DONE;
                end else begin
                    word_cnt_next = '0;
                    slot_next     = '0;
                    state_next    = ST_WALK;
                end
            end
            ST_INS_SCAN: begin
                if (!slot_valid_reg[slot_reg]) begin
                    word_cnt_next = '0;
                    state_next    = (copy_words == 5'd0) ? ST_INS_META : ST_COPY_RD;
                end else if (slot_reg == SLOT_W'(SLOTS - 1)) begin
                    res_status_next = STAT_FULL;
                    state_next      = ST_DONE;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                name_we = 1'b1;
                if ({1'b0, word_cnt_reg} == copy_words - 5'd1) begin
                    state_next = ST_INS_META;
                end else begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                    state_next    = ST_COPY_RD;
                end
            end
            ST_INS_META: begin
                meta_we                   = 1'b1;
                slot_valid_next[slot_reg] = 1'b1;
                count_next                = count_reg + 8'd1;
                res_status_next           = STAT_OK;
                state_next                = ST_DONE;
            end
            ST_WALK: begin
                state_next = slot_valid_reg[slot_reg] ? ST_W_LEN : ST_NEXT;
            end
            ST_W_LEN: begin
                if ({1'b0, meta_rdata_reg.name_len} != len_reg) begin
                    state_next = ST_NEXT;
                end else if (len_reg == 8'd0) begin
                    state_next = ST_MATCH;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!cmp_eq) begin
                    state_next = ST_NEXT;
                end else if ({1'b0, word_cnt_reg} == cmp_words - 5'd1) begin
                    state_next = ST_MATCH;
                end else begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                    state_next    = ST_CMP_WAIT;
                end
            end
            ST_CMP_WAIT: state_next = ST_CMP;
            ST_MATCH: begin
                if (op_reg == REQ_REMOVE) begin
                    slot_valid_next[slot_reg] = 1'b0;
                    count_next                = count_reg - 8'd1;
                    res_status_next           = STAT_OK;
                    state_next                = ST_DONE;
                end else begin
                    // Compare age against lifetime scaled to ticks
                    prod_next = 56'(meta_rdata_reg.lifetime) * 56'(TICKS_PER_SECOND);
                    ge_next   = (now_reg >= meta_rdata_reg.insert_time);
                    diff_next = (now_reg >= meta_rdata_reg.insert_time)
                              ? now_reg - meta_rdata_reg.insert_time
                              : meta_rdata_reg.insert_time - now_reg;
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                if (expired) begin
                    slot_valid_next[slot_reg] = 1'b0;
                    count_next                = count_reg - 8'd1;
                    state_next                = ST_NEXT;
                end else begin
                    res_status_next = STAT_OK;
                    res_addr_next   = meta_rdata_reg.address;
                    state_next      = ST_DONE;
                end
            end
            ST_NEXT: begin
                word_cnt_next = '0;
                if (slot_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_DONE: begin
                // Hold here while the previous result still waits
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_count_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            count_reg      <= 8'd0;
            enabled_reg    <= 1'b0;
            rlen_reg       <= 8'd0;
            zfound_reg     <= 1'b0;
            partial_reg    <= 64'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            rlen_reg       <= rlen_next;
            zfound_reg     <= zfound_next;
            partial_reg    <= partial_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                enabled_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        word_cnt_reg   <= word_cnt_next;
        zpos_reg       <= zpos_next;
        op_reg         <= op_next;
        addr_in_reg    <= addr_in_next;
        ttl_reg        <= ttl_next;
        now_reg        <= now_next;
        len_reg        <= len_next;
        loc_ok_reg     <= loc_ok_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        prod_reg       <= prod_next;
        diff_reg       <= diff_next;
        ge_reg         <= ge_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_count_reg    <= m_count_next;
    end

    // Request name buffer
    always_ff @(posedge aclk) begin
        if (req_we) begin
            req_mem[req_waddr] <= req_wdata;
        end
        req_rdata_reg <= req_mem[word_cnt_reg];
    end

    // Stored names, one row of words per slot
    always_ff @(posedge aclk) begin
        if (name_we) begin
            slot_name_mem[{slot_reg, word_cnt_reg}] <= req_rdata_reg;
        end
        name_rdata_reg <= slot_name_mem[{slot_reg, word_cnt_reg}];
    end

    // Per-slot length, address, lifetime and insert time
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[slot_reg] <= meta_wdata;
        end
        meta_rdata_reg <= meta_mem[slot_reg];
    end

    // Occupancy count tracks the valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_valid_reg) == 32'(count_reg))
        else $error("slot count disagrees with valid bits");

    // A result appears only from the final sequencer state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final state");

    // Name buffer never overflows
    assert property (@(posedge aclk) disable iff (!aresetn)
        rlen_reg <= 8'(NAME_BYTES))
        else $error("request name length overflow");

    // A finished request is not lost while the receiver stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> state_reg == ST_DONE)
        else $error("result dropped under stall");

endmodule

/* tb/sv/name_cache_checker.sv */
`timescale 1ns / 1ps
module name_cache_checker import ncexp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_name_chunk,
    input  logic [3:0]  s_chunk_bytes,
    input  logic        s_last_chunk,
    input  logic [31:0] s_entry_address,
    input  logic [31:0] s_ttl_seconds,
    input  logic [63:0] s_now_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_found_address,
    input  logic [7:0]  m_entries_in_use,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
        logic [7:0]  in_use;
    } answer_t;

    answer_t     answers_due[$];
    logic        cache_on;
    logic        slot_live [SLOTS];
    logic [7:0]  slot_chars [SLOTS][NAME_BYTES];
    int          slot_len [SLOTS];
    logic [31:0] slot_addr [SLOTS];
    logic [31:0] slot_ttl [SLOTS];
    logic [63:0] slot_t0 [SLOTS];
    logic [7:0]  req_chars [NAME_BYTES];
    int          req_len;
    int          live_count;

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit name_equal(input int s, input int len);
        if (slot_len[s] != len) return 0;
        for (int i = 0; i < len; i++)
            if (lower(slot_chars[s][i]) != lower(req_chars[i])) return 0;
        return 1;
    endfunction

    function automatic bit is_stale(input int s, input logic [63:0] now);
        logic [63:0] age;
        if (now >= slot_t0[s]) age = (now - slot_t0[s]) / 64'd10000000;
        else if (slot_t0[s] - now >= 64'd10000000) return 1;
        else age = 0;
        return age >= {32'd0, slot_ttl[s]};
    endfunction

    function automatic void drop_slot(input int s);
        if (slot_live[s]) live_count--;
        slot_live[s] = 0;
    endfunction

    // Absorb one chunk; on the last chunk run the request and queue its answer.
    function automatic void lookup_step();
        int n, len;
        bit done;
        string lh;
        answer_t a;
        n = (s_chunk_bytes > CHUNK_CHARS) ? CHUNK_CHARS : s_chunk_bytes;
        for (int i = 0; i < n; i++)
            if (req_len < NAME_BYTES) begin
                req_chars[req_len] = s_name_chunk[8*i +: 8];
                req_len++;
            end
        if (!s_last_chunk) return;
        len = req_len;
        for (int i = 0; i < req_len; i++)
            if (req_chars[i] == 0) begin
                len = i;
                break;
            end
        req_len = 0;
        a.status = STAT_NOT_FOUND;
        a.address = '0;
        done = 0;
        case (s_req_type)
            REQ_INSERT: begin
                if (!cache_on) a.status = STAT_REJECTED;
                else begin
                    a.status = STAT_FULL;
                    for (int s = 0; s < SLOTS && !done; s++)
                        if (!slot_live[s]) begin
                            slot_live[s] = 1;
                            live_count++;
                            slot_len[s] = (len < NAME_BYTES - 1) ? len : NAME_BYTES - 1;
                            for (int i = 0; i < slot_len[s]; i++)
                                slot_chars[s][i] = req_chars[i];
                            slot_addr[s] = s_entry_address;
                            slot_ttl[s] = s_ttl_seconds;
                            slot_t0[s] = s_now_time;
                            a.status = STAT_OK;
                            done = 1;
                        end
                end
            end
            REQ_REMOVE: begin
                for (int s = 0; s < SLOTS && !done; s++)
                    if (slot_live[s] && name_equal(s, len)) begin
                        drop_slot(s);
                        a.status = STAT_OK;
                        done = 1;
                    end
            end
            REQ_RESOLVE: begin
                lh = "localhost";
                done = (len == 9);
                for (int i = 0; i < 9 && done; i++)
                    if (lower(req_chars[i]) != lh[i]) done = 0;
                if (done) begin
                    a.status = STAT_OK;
                    a.address = LOCAL_ADDRESS;
                end else
                    for (int s = 0; s < SLOTS && !done; s++) begin
                        if (!slot_live[s] || !name_equal(s, len)) continue;
                        if (is_stale(s, s_now_time)) begin
                            drop_slot(s);
                            continue;
                        end
                        a.status = STAT_OK;
                        a.address = slot_addr[s];
                        done = 1;
                    end
            end
            default: begin
                for (int s = 0; s < SLOTS; s++) slot_live[s] = 0;
                live_count = 0;
                a.status = STAT_OK;
            end
        endcase
        a.in_use = (live_count > 255) ? 8'd255 : live_count[7:0];
        answers_due.push_back(a);
    endfunction

    assign pending_count = answers_due.size();

    always @(posedge aclk) begin
        answer_t e;
        if (!aresetn) begin
            cache_on <= 0;
            req_len = 0;
            live_count = 0;
            for (int s = 0; s < SLOTS; s++) slot_live[s] = 0;
            answers_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) cache_on <= cfg_wr_data;
            if (s_valid && s_ready) lookup_step();
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result: %0d %h %0d",
                        m_status, m_found_address, m_entries_in_use);
                    fail_count <= fail_count + 1;
                end else begin
                    e = answers_due.pop_front();
                    if (e !== {m_status, m_found_address, m_entries_in_use}) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %0d %h %0d got %0d %h %0d",
                                e.status, e.address, e.in_use,
                                m_status, m_found_address, m_entries_in_use);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import ncexp_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic        cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [63:0] s_name_chunk = '0;
    logic [3:0]  s_chunk_bytes = '0;
    logic        s_last_chunk = 0;
    logic [31:0] s_entry_address = '0;
    logic [31:0] s_ttl_seconds = '0;
    logic [63:0] s_now_time = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [31:0] m_found_address;
    logic [7:0]  m_entries_in_use;
    int          fail_count;
    int          pending_count;

    // Small pool of names so inserts, lookups and removes actually collide.
    logic [63:0] name_pool [8];
    int          name_len_pool [8];
    logic [63:0] clock_now = 64'd1_000_000_000;
    int          burst_left = 0;

    always #1 aclk = ~aclk;

    name_cache_with_expiry_top dut (.*);

    name_cache_checker checker_i (.*);

    // Receiver stalls on its own pattern: long ready stretches, then choppy ones.
    always @(posedge aclk) begin
        int phase;
        phase = $urandom_range(0, 99);
        m_ready <= ($time % 4000 < 1000) ? 1'b1 : (phase < 65);
    end

    // Present one chunk and hold it until the handshake; gaps come in bursts.
    task automatic send_chunk(input logic [1:0] op, input logic [63:0] chunk,
                              input logic [3:0] nbytes, input logic last,
                              input logic [31:0] addr, input logic [31:0] ttl,
                              input logic [63:0] now);
        if (burst_left == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1;
        s_req_type <= op;
        s_name_chunk <= chunk;
        s_chunk_bytes <= nbytes;
        s_last_chunk <= last;
        s_entry_address <= addr;
        s_ttl_seconds <= ttl;
        s_now_time <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stream a whole request: optional long filler chunks, then the pool name as the last chunk.
    task automatic send_request(input logic [1:0] op, input int which,
                                input int extra_words, input logic [31:0] ttl,
                                input logic [63:0] now);
        logic [63:0] filler;
        for (int w = 0; w < extra_words; w++) begin
            filler = {$urandom, $urandom} | 64'h0101_0101_0101_0101;
            send_chunk(op, filler, 4'($urandom_range(0, 15)), 0, '0, '0, '0);
        end
        send_chunk(op, name_pool[which], 4'(name_len_pool[which]), 1,
                   $urandom, ttl, now);
    endtask

    // Hold stimulus until every expected result is back, then let the block settle.
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_enable(input logic on);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    initial begin
        logic [1:0] op;
        int pick;
        name_pool[0] = 64'h736F_686C_6163_6F6C; name_len_pool[0] = 8;  // "localhos"
        name_pool[1] = 64'h0000_0000_006F_6F66; name_len_pool[1] = 3;  // "foo"
        name_pool[2] = 64'h0000_0000_004F_4F46; name_len_pool[2] = 3;  // "FOO"
        name_pool[3] = 64'h0000_0062_6100_7A78; name_len_pool[3] = 8;  // zero mid-name
        name_pool[4] = 64'h6867_6665_6463_6261; name_len_pool[4] = 8;
        name_pool[5] = '1;                     name_len_pool[5] = 15;
        name_pool[6] = '0;                     name_len_pool[6] = 0;
        name_pool[7] = 64'h0000_0000_0000_5A41; name_len_pool[7] = 2;  // "AZ"
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: insert while disabled, then the edge cases.
        send_request(REQ_INSERT, 1, 0, 5, clock_now);
        send_request(REQ_RESOLVE, 1, 0, 0, clock_now);
        set_enable(1);
        // "localhost": eight characters then the final 't', upper case mixed in.
        send_chunk(REQ_RESOLVE, 64'h736F_484C_6163_6F6C, 8, 0, '0, '0, '0);
        send_chunk(REQ_RESOLVE, 64'h74, 1, 1, '0, '0, clock_now);
        send_request(REQ_INSERT, 1, 0, 0, clock_now);           // zero lifetime
        send_request(REQ_RESOLVE, 2, 0, 0, clock_now);          // expires, case folded
        send_request(REQ_INSERT, 2, 0, '1, clock_now);
        send_request(REQ_RESOLVE, 1, 0, 0, clock_now - 64'd5_000_000);  // small step back
        send_request(REQ_RESOLVE, 1, 0, 0, clock_now - 64'd20_000_000); // big step back
        send_request(REQ_INSERT, 5, 17, 3, clock_now);          // overlong name
        send_request(REQ_RESOLVE, 5, 17, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_INSERT, 3, 0, 7, clock_now);
        send_request(REQ_REMOVE, 3, 0, 0, clock_now);
        send_request(REQ_REMOVE, 3, 0, 0, clock_now);
        send_request(REQ_INSERT, 6, 0, 1, 64'd0);
        send_request(REQ_RESOLVE, 6, 0, 0, 64'd0);
        // Fill the table until it reports full.
        for (int i = 0; i < 130; i++) send_request(REQ_INSERT, 7, 0, '1, clock_now);
        send_request(REQ_FLUSH, 4, 0, 0, clock_now);

        // Random: mostly well-formed requests on pooled names with advancing time.
        for (int n = 0; n < 950; n++) begin
            if (n == 300) set_enable(0);
            if (n == 400) set_enable(1);
            if (n == 700) drain();
            clock_now += $urandom_range(0, 30_000_000);
            pick = $urandom_range(1, 7);
            op = $urandom_range(0, 99) < 40 ? REQ_INSERT :
                 $urandom_range(0, 99) < 70 ? REQ_RESOLVE :
                 $urandom_range(0, 99) < 96 ? REQ_REMOVE : REQ_FLUSH;
            if ($urandom_range(0, 19) == 0) begin
                send_chunk(op, {$urandom, $urandom}, 4'($urandom_range(0, 15)), 1,
                           $urandom, $urandom, {$urandom, $urandom});
            end else
                send_request(op, pick, $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0,
                             $urandom_range(0, 4), clock_now);
        end

        drain();
        if (fail_count == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
